### sv/hbbc_pkg.sv
// Shared types and constants for the hashed block buffer cache.
// Holds command and status codes, controller states and the slot record.
// No dependencies.
package hbbc_pkg;

  // Widest bucket index and recency rank over the supported configurations
  localparam int BKT_W  = 4;
  localparam int RANK_W = 6;
  localparam int BCNT_W = 7;
  localparam int CNT_W8 = 8;

  typedef enum logic [1:0] {
    CMD_GET     = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PIN     = 2'd2,
    CMD_UNPIN   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOFREE    = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_RD,
    S_OP,
    S_DECIDE,
    S_UPD,
    S_RESP
  } state_t;

  // One buffer slot as held in the slot memory
  typedef struct packed {
    logic [15:0]       dev;
    logic [31:0]       blk;
    logic              valid;
    logic [CNT_W8-1:0] refs;
    logic [BKT_W-1:0]  bkt;
    logic [RANK_W-1:0] rank;
  } slot_rec_t;

endpackage

### sv/hbbc_if.sv
// Request and response channel interfaces of the buffer cache.
// Depends on nothing; payload widths follow the command and result fields.
interface hbbc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] device;
  logic [31:0] block_number;
  logic [4:0]  slot_in;

  modport source (output valid, command, device, block_number, slot_in, input ready);
  modport sink   (input valid, command, device, block_number, slot_in, output ready);
endinterface

interface hbbc_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] slot_out;
  logic       cache_hit;
  logic       needs_fill;
  logic [1:0] status;

  modport source (output valid, slot_out, cache_hit, needs_fill, status, input ready);
  modport sink   (input valid, slot_out, cache_hit, needs_fill, status, output ready);
endinterface

### sv/hbbc_mem.sv
// Slot record memory: one write port, one read port, registered read data.
// Depends on hbbc_pkg for the slot record type.
module hbbc_mem
  import hbbc_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_rec_t     wdata,
  input  logic [AW-1:0] raddr,
  output slot_rec_t     rdata
);

  slot_rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/hbbc_mod.sv
// Remainder of a 32-bit block number by the bucket count.
// Nibbles are weighted by 16**i reduced by the bucket count, then a reciprocal multiply
// gives the remainder; done follows start through st1 and st2. Depends on hbbc_pkg.
module hbbc_mod
  import hbbc_pkg::*;
#(
  parameter int NUM_BUCKETS = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      value,
  output logic             done,
  output logic [BKT_W-1:0] rem
);

  // weight of nibble i: 16**i reduced by the bucket count
  function automatic int nib_wt(int i);
    int w;
    w = 1 % NUM_BUCKETS;
    for (int j = 0; j < i; j++) begin
      w = (w * 16) % NUM_BUCKETS;
    end
    return w;
  endfunction

  localparam int WT [8] = '{nib_wt(0), nib_wt(1), nib_wt(2), nib_wt(3),
                            nib_wt(4), nib_wt(5), nib_wt(6), nib_wt(7)};
  // reciprocal, exact for sums below 2**11
  localparam int RECIP = (65536 + NUM_BUCKETS - 1) / NUM_BUCKETS;

  logic [31:0] sh;
  logic [10:0] acc;
  logic [10:0] wsum;
  logic [27:0] prod;
  logic [10:0] quo;
  logic        st1, st2;

  // weighted nibble sum, congruent to the value, at most 1800
  always_comb begin
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      acc = acc + 11'(sh[4*i +: 4]) * 11'(WT[i]);
    end
  end

  assign prod = 28'(wsum) * 28'(RECIP);
  assign quo  = 11'(prod >> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      st1  <= 1'b0;
      st2  <= 1'b0;
      done <= 1'b0;
    end else begin
      st1  <= start;
      st2  <= st1;
      done <= st2;
      if (start) begin
        sh <= value;
      end
      if (st1) begin
        wsum <= acc;
      end
      if (st2) begin
        rem <= BKT_W'(wsum - quo * 11'(NUM_BUCKETS));
      end
    end
  end

endmodule

### sv/hashed_block_buffer_cache.sv
// Hashed buffer cache with per-bucket recency order, slot records in one memory.
// Get: the bucket remainder, then a tag scan and decision, then an update
// pass on a miss that finds a free slot. Pin, unpin and release read and
// modify the slot; a release that frees a slot adds a scan and an update pass.
// One item in flight; the output register lets the next item enter while it waits.
// After reset a sweep clears every slot record and sets its rank; no item
// is taken until it ends. Depends on hbbc_pkg, hbbc_if, hbbc_mem, hbbc_mod.
module hashed_block_buffer_cache
  import hbbc_pkg::*;
#(
  parameter int NUM_BUFFERS = 32,
  parameter int NUM_BUCKETS = 13
) (
  input  logic        clk,
  input  logic        rst,
  hbbc_req_if.sink    req,
  hbbc_rsp_if.source  rsp
);

  localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int CW    = $clog2(NUM_BUFFERS + 1);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_BUFFERS - 1);

  state_t state, state_next;

  // latched request
  cmd_t             cmd;
  logic [15:0]      q_dev;
  logic [31:0]      q_blk;
  logic [IDX_W-1:0] sidx;

  // pass control
  logic [CW-1:0]    cnt;
  logic             rv;
  logic [IDX_W-1:0] raq;

  // scan results
  logic [BKT_W-1:0]  hb;
  logic              hf, ff;
  logic [IDX_W-1:0]  hidx, fidx;
  slot_rec_t         hrec, frec;
  logic [BKT_W:0]    fd;
  logic [BCNT_W-1:0] bcnt;

  // update pass
  logic [IDX_W-1:0]  tgt;
  logic [BKT_W-1:0]  ob;
  logic [RANK_W-1:0] orank;
  slot_rec_t         nrec;

  // result register
  logic [4:0] r_slot;
  logic       r_hit, r_fill;
  status_t    r_status;

  // memory port
  logic             we;
  logic [IDX_W-1:0] wa, ra;
  slot_rec_t        wd, rd;

  logic             mod_start, mod_done;
  logic [BKT_W-1:0] mod_rem;
  logic             issue;
  logic [BKT_W:0]   bdist;
  logic             in_range;

  hbbc_mem #(.DEPTH(NUM_BUFFERS), .AW(IDX_W)) u_mem (
    .clk(clk), .we(we), .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd)
  );

  hbbc_mod #(.NUM_BUCKETS(NUM_BUCKETS)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .value(req.block_number),
    .done(mod_done), .rem(mod_rem)
  );

  assign issue    = (cnt < CW'(NUM_BUFFERS));
  assign in_range = ({2'b00, req.slot_in} < 7'(NUM_BUFFERS));
  assign req.ready = (state == S_IDLE);

  // cyclic distance of a slot's bucket from the searched bucket
  always_comb begin
    if (rd.bkt >= hb) begin
      bdist = {1'b0, rd.bkt} - {1'b0, hb};
    end else begin
      bdist = {1'b0, rd.bkt} + (BKT_W+1)'(NUM_BUCKETS) - {1'b0, hb};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory port
  always_comb begin
    state_next = state;
    mod_start  = 1'b0;
    we         = 1'b0;
    wa         = raq;
    wd         = rd;
    ra         = cnt[IDX_W-1:0];
    unique case (state)
      S_CLEAR: begin
        we      = 1'b1;
        wa      = cnt[IDX_W-1:0];
        wd      = '0;
        wd.rank = RANK_W'(cnt);
        if (cnt[IDX_W-1:0] == LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          if (cmd_t'(req.command) == CMD_GET) begin
            mod_start  = 1'b1;
            state_next = S_MOD;
          end else if (in_range) begin
            state_next = S_RD;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rv && raq == LAST) begin
          state_next = S_DECIDE;
        end
      end
      S_RD: begin
        ra         = sidx;
        state_next = S_OP;
      end
      S_OP: begin
        wa = sidx;
        if (cmd == CMD_PIN) begin
          we         = 1'b1;
          wd.refs    = (rd.refs == 8'hFF) ? rd.refs : rd.refs + 8'd1;
          state_next = S_RESP;
        end else if (rd.refs == 8'd0) begin
          state_next = S_RESP;
        end else if (cmd == CMD_RELEASE && rd.refs == 8'd1) begin
          state_next = S_SCAN;
        end else begin
          we         = 1'b1;
          wd.refs    = rd.refs - 8'd1;
          state_next = S_RESP;
        end
      end
      S_DECIDE: begin
        if (cmd == CMD_GET && hf) begin
          we         = 1'b1;
          wa         = hidx;
          wd         = hrec;
          wd.valid   = 1'b1;
          wd.refs    = (hrec.refs == 8'hFF) ? hrec.refs : hrec.refs + 8'd1;
          state_next = S_RESP;
        end else if (cmd == CMD_GET && !ff) begin
          state_next = S_RESP;
        end else begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (rv) begin
          if (raq == tgt) begin
            we = 1'b1;
            wd = nrec;
          end else if (rd.bkt == ob && rd.rank > orank) begin
            we      = 1'b1;
            wd.rank = rd.rank - RANK_W'(1);
          end
          if (raq == LAST) begin
            state_next = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pass counter and read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rv  <= 1'b0;
    end else begin
      rv  <= (state == S_SCAN || state == S_UPD) && issue;
      raq <= cnt[IDX_W-1:0];
      if (state == S_SCAN || state == S_UPD || state == S_CLEAR) begin
        if (issue) begin
          cnt <= cnt + CW'(1);
        end
      end else begin
        cnt <= '0;
      end
    end
  end

  // request latch, scan accumulation and result
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      cmd      <= cmd_t'(req.command);
      q_dev    <= req.device;
      q_blk    <= req.block_number;
      sidx     <= IDX_W'(req.slot_in);
      r_slot   <= req.slot_in;
      r_hit    <= 1'b0;
      r_fill   <= 1'b0;
      r_status <= ST_OK;
    end
    if (state == S_IDLE || state == S_OP) begin
      hf   <= 1'b0;
      ff   <= 1'b0;
      bcnt <= '0;
    end
    if (state == S_MOD && mod_done) begin
      hb <= mod_rem;
    end
    if (state == S_OP) begin
      hb    <= rd.bkt;
      tgt   <= sidx;
      ob    <= rd.bkt;
      orank <= rd.rank;
      nrec  <= '{dev: rd.dev, blk: rd.blk, valid: rd.valid, refs: '0,
                 bkt: rd.bkt, rank: rd.rank};
      if (cmd != CMD_PIN && rd.refs == 8'd0) begin
        r_status <= ST_UNDERFLOW;
      end
    end
    // one record per cycle during the scan
    if (state == S_SCAN && rv) begin
      if (rd.bkt == hb) begin
        bcnt <= bcnt + BCNT_W'(1);
      end
      if (rd.bkt == hb && rd.dev == q_dev && rd.blk == q_blk &&
          (!hf || rd.rank > hrec.rank)) begin
        hf   <= 1'b1;
        hidx <= raq;
        hrec <= rd;
      end
      if (rd.refs == 8'd0 &&
          (!ff || bdist < fd || (bdist == fd && rd.rank < frec.rank))) begin
        ff   <= 1'b1;
        fidx <= raq;
        frec <= rd;
        fd   <= bdist;
      end
    end
    if (state == S_DECIDE) begin
      if (cmd == CMD_GET) begin
        if (hf) begin
          r_slot <= 5'(hidx);
          r_hit  <= 1'b1;
          r_fill <= !hrec.valid;
        end else if (ff) begin
          r_slot <= 5'(fidx);
          r_fill <= 1'b1;
          tgt    <= fidx;
          ob     <= frec.bkt;
          orank  <= frec.rank;
          nrec   <= '{dev: q_dev, blk: q_blk, valid: 1'b1, refs: 8'd1, bkt: hb,
                      rank: RANK_W'(bcnt - ((frec.bkt == hb) ? BCNT_W'(1) : BCNT_W'(0)))};
        end else begin
          r_slot   <= '0;
          r_status <= ST_NOFREE;
        end
      end else begin
        nrec.rank <= RANK_W'(bcnt - BCNT_W'(1));
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_RESP && (!rsp.valid || rsp.ready)) begin
      rsp.valid      <= 1'b1;
      rsp.slot_out   <= r_slot;
      rsp.cache_hit  <= r_hit;
      rsp.needs_fill <= r_fill;
      rsp.status     <= r_status;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the hashed block buffer cache.
// Drives get, release, pin and unpin transfers and checks every response
// against an in-bench model. Depends on hbbc_pkg, hbbc_if and the RTL.
module testbench
  import hbbc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUF  = 32;
  localparam int NBKT  = 13;
  localparam int LIMIT = 2_000_000;

  typedef struct packed {
    logic [4:0] slot;
    logic       hit;
    logic       fill;
    logic [1:0] status;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic no_idle = 1'b0;
  int   errors = 0;
  int   cycles = 0;

  hbbc_req_if req ();
  hbbc_rsp_if rsp ();

  hashed_block_buffer_cache #(.NUM_BUFFERS(NBUF), .NUM_BUCKETS(NBKT)) i_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  always #10 clk = ~clk;

  // Model of the slot table
  logic [15:0] m_dev  [NBUF];
  logic [31:0] m_blk  [NBUF];
  logic        m_vld  [NBUF];
  logic [7:0]  m_refs [NBUF];
  int          m_bkt  [NBUF];
  int          m_rank [NBUF];
  rsp_t        pending [$];
  // Tags handed out, reused to produce hits
  logic [47:0] used_tags [$];

  function automatic void model_reset();
    for (int i = 0; i < NBUF; i++) begin
      m_dev[i] = '0; m_blk[i] = '0; m_vld[i] = 1'b0; m_refs[i] = '0;
      m_bkt[i] = 0; m_rank[i] = i;
    end
  endfunction

  // Remove slot from its bucket order and append at the recent end of b
  function automatic void move_recent(int s, int b);
    int n;
    n = 0;
    for (int i = 0; i < NBUF; i++)
      if (i != s && m_bkt[i] == m_bkt[s] && m_rank[i] > m_rank[s]) m_rank[i]--;
    for (int i = 0; i < NBUF; i++)
      if (i != s && m_bkt[i] == b) n++;
    m_bkt[s] = b;
    m_rank[s] = n;
  endfunction

  function automatic rsp_t predict_cache(cmd_t c, logic [15:0] d, logic [31:0] bn,
                                         logic [4:0] s);
    rsp_t r;
    int h, found, b;
    r = '{slot: s, hit: 1'b0, fill: 1'b0, status: ST_OK};
    if (c == CMD_GET) begin
      h = int'(bn % NBKT);
      found = -1;
      for (int i = 0; i < NBUF; i++)
        if (m_bkt[i] == h && m_dev[i] == d && m_blk[i] == bn &&
            (found < 0 || m_rank[i] > m_rank[found])) found = i;
      if (found >= 0) begin
        if (m_refs[found] != 8'd255) m_refs[found]++;
        r.hit = 1'b1;
      end else begin
        for (int k = 0; k < NBKT && found < 0; k++) begin
          b = (h + k) % NBKT;
          for (int i = 0; i < NBUF; i++)
            if (m_bkt[i] == b && m_refs[i] == 0 &&
                (found < 0 || m_rank[i] < m_rank[found])) found = i;
        end
        if (found >= 0) begin
          m_dev[found] = d; m_blk[found] = bn; m_vld[found] = 1'b0;
          m_refs[found] = 8'd1;
          move_recent(found, h);
        end
      end
      if (found >= 0) begin
        r.slot = found[4:0];
        r.fill = ~m_vld[found];
        m_vld[found] = 1'b1;
      end else begin
        r.slot = '0;
        r.status = ST_NOFREE;
      end
    end else if (s < NBUF) begin
      if (c == CMD_PIN) begin
        if (m_refs[s] != 8'd255) m_refs[s]++;
      end else if (m_refs[s] == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        m_refs[s]--;
        if (c == CMD_RELEASE && m_refs[s] == 0) move_recent(s, m_bkt[s]);
      end
    end
    return r;
  endfunction

  // Send one transfer, with an optional random gap before it; valid stays
  // high after the transfer so back-to-back items need no second assignment
  task automatic send_item(cmd_t c, logic [15:0] d, logic [31:0] bn, logic [4:0] s);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.command      <= c;
    req.device       <= d;
    req.block_number <= bn;
    req.slot_in      <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    pending.push_back(predict_cache(c, d, bn, s));
    if (c == CMD_GET) used_tags.push_back({d, bn});
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Response sink with random back-pressure
  initial begin
    int stall;
    stall = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (pending.size() == 0) begin
          $display("%0t: unexpected response slot %0d", $time, rsp.slot_out);
          errors++;
        end else begin
          rsp_t e;
          e = pending.pop_front();
          if (e.slot !== rsp.slot_out || e.hit !== rsp.cache_hit ||
              e.fill !== rsp.needs_fill || e.status !== rsp.status) begin
            $display("%0t: expected slot %0d hit %0b fill %0b status %0d, got %0d %0b %0b %0d",
                     $time, e.slot, e.hit, e.fill, e.status,
                     rsp.slot_out, rsp.cache_hit, rsp.needs_fill, rsp.status);
            errors++;
          end
        end
      end
      if (stall > 0) stall--;
      else if (!no_idle && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 15);
      rsp.ready <= (stall == 0);
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Reset tags, extremes of fields, the highest slot index and underflow
  task automatic test_directed();
    send_item(CMD_GET, 16'h0, 32'h0, 5'd0);
    send_item(CMD_GET, 16'h0, 32'h0, 5'd31);
    send_item(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
    send_item(CMD_GET, 16'h1234, 32'd13, 5'd0);
    send_item(CMD_PIN, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    send_item(CMD_UNPIN, 16'h0, 32'h0, 5'd31);
    send_item(CMD_UNPIN, 16'h0, 32'h0, 5'd31);
    send_item(CMD_RELEASE, 16'h0, 32'h0, 5'd5);
    send_item(CMD_RELEASE, 16'h0, 32'h0, 5'd31);
    send_item(CMD_RELEASE, 16'h0, 32'h0, 5'd31);
    send_item(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
    send_item(CMD_RELEASE, 16'h0, 32'h0, 5'd30);
    send_item(CMD_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0);
  endtask

  // Fill every slot, then a get finds no free buffer; drain again
  task automatic test_no_free();
    for (int i = 0; i < NBUF + 2; i++)
      send_item(CMD_GET, 16'hA5A5, 32'h1000 + i, 5'($urandom));
    send_item(CMD_GET, 16'h0F0F, 32'h7777, 5'd3);
    wait_drained();
    for (int i = 0; i < NBUF; i++)
      while (m_refs[i] != 0) send_item(CMD_RELEASE, '0, '0, 5'(i));
  endtask

  // Pin one slot up to saturation, then unpin it down to an underflow
  task automatic test_saturation();
    for (int i = 0; i < 258; i++) begin
      no_idle = 1'b1;
      send_item(CMD_PIN, '0, '0, 5'd7);
    end
    no_idle = 1'b0;
    while (m_refs[7] != 0) begin
      no_idle = 1'b1;
      send_item(CMD_UNPIN, '0, '0, 5'd7);
    end
    send_item(CMD_UNPIN, '0, '0, 5'd7);
    no_idle = 1'b0;
  endtask

  // Random mix, biased to reuse tags and small block numbers
  task automatic test_random(int n, bit quiet);
    cmd_t c;
    logic [15:0] d;
    logic [31:0] bn;
    logic [47:0] t;
    no_idle = quiet;
    for (int i = 0; i < n; i++) begin
      c = cmd_t'($urandom_range(0, 3));
      d = 16'($urandom_range(0, 3));
      bn = $urandom_range(0, 40);
      case ($urandom_range(0, 9))
        0: begin d = 16'($urandom); bn = $urandom; end
        1, 2, 3: if (used_tags.size() != 0) begin
          t = used_tags[$urandom_range(0, used_tags.size() - 1)];
          {d, bn} = t;
        end
        default: ;
      endcase
      send_item(c, d, bn, 5'($urandom));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    model_reset();
    req.valid <= 1'b0;
    req.command <= CMD_GET;
    req.device <= '0;
    req.block_number <= '0;
    req.slot_in <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_free();
    test_random(50, 1'b0);
    wait_drained();
    test_random(50, 1'b0);
    test_saturation();
    test_random(40, 1'b1);
    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
